### src/mu8_pkg.sv
// mu8_pkg: shared types and constants of the modified UTF-8 to UTF-8 converter.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package mu8_pkg;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2,
        KIND_SIX   = 2'd3
    } t_kind;

    localparam int unsigned GROUP_MAX = 5;
    localparam int unsigned CNT_W     = 3;

    localparam logic [7:0]  BYTE_ED   = 8'hED;
    localparam logic [7:0]  BYTE_C0   = 8'hC0;
    localparam logic [7:0]  BYTE_80   = 8'h80;
    localparam logic [7:0]  BYTE_NUL  = 8'h00;
    localparam logic [3:0]  HI_SURR   = 4'hA;
    localparam logic [2:0]  LEAD2_TAG = 3'b110;
    localparam logic [3:0]  LEAD3_TAG = 4'b1110;
    localparam logic [7:0]  LEAD4_PFX = 8'hF0;
    localparam logic [7:0]  CONT_PFX  = 8'h80;
    localparam logic [20:0] CP_OFFSET = 21'h10000;

    // bytes released by one input transaction, bytes[0] goes out first
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          num;
        logic                      last;
    } t_group;

endpackage

`default_nettype wire

### src/mu8_in_if.sv
// mu8_in_if: valid/ready channel carrying one modified UTF-8 input byte.
// No dependencies.
`default_nettype none

interface mu8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### src/mu8_out_if.sv
// mu8_out_if: valid/ready channel carrying one standard UTF-8 output byte.
// No dependencies.
`default_nettype none

interface mu8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                     input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                     output ready);
endinterface

`default_nettype wire

### src/mu8_front.sv
// mu8_front: accepts input bytes, tracks the open sequence and forms output groups.
// Depends on mu8_pkg and mu8_in_if.
`default_nettype none

module mu8_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mu8_in_if.sink           i_in,
    output logic             o_push_valid,
    input  wire              i_push_ready,
    output mu8_pkg::t_group  o_push_group
);

    mu8_pkg::t_kind                   r_kind, n_kind;
    logic [mu8_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [mu8_pkg::GROUP_MAX-1:0][7:0] r_buf;

    logic [5:0][7:0]                  wb;
    logic [mu8_pkg::CNT_W-1:0]        cnt1;
    logic [mu8_pkg::CNT_W-1:0]        kept;
    logic                             lead2, lead3, enter_six, done, flush, accept;
    logic [19:0]                      cp_raw;
    logic [20:0]                      cp;
    mu8_pkg::t_group                  grp;

    assign accept = i_in.valid && i_in.ready;

    // decode
    always_comb begin
        wb          = {8'h00, r_buf};
        wb[r_cnt]   = i_in.in_byte;
        cnt1        = r_cnt + 1'b1;
        lead2       = i_in.in_byte[7:5] == mu8_pkg::LEAD2_TAG;
        lead3       = i_in.in_byte[7:4] == mu8_pkg::LEAD3_TAG;
        enter_six   = (r_kind == mu8_pkg::KIND_THREE) && (r_cnt == 3'd1) &&
                      (r_buf[0] == mu8_pkg::BYTE_ED) &&
                      (i_in.in_byte[7:4] == mu8_pkg::HI_SURR);
        done        = (r_kind == mu8_pkg::KIND_TWO) ||
                      ((r_kind == mu8_pkg::KIND_THREE) && !enter_six && (cnt1 >= 3'd3)) ||
                      ((r_kind == mu8_pkg::KIND_SIX) && (cnt1 >= 3'd6));
        if (r_kind == mu8_pkg::KIND_NONE) begin
            kept = (lead2 || lead3) ? 3'd1 : 3'd0;
        end else begin
            kept = done ? 3'd0 : cnt1;
        end
        flush  = i_in.in_last && (kept != 3'd0);
        cp_raw = {wb[1][3:0], wb[2][5:0], wb[4][3:0], wb[5][5:0]};
        cp     = {1'b0, cp_raw} + mu8_pkg::CP_OFFSET;
    end

    // next state
    always_comb begin
        n_kind = r_kind;
        n_cnt  = kept;
        if ((kept == 3'd0) || i_in.in_last) begin
            n_kind = mu8_pkg::KIND_NONE;
            n_cnt  = 3'd0;
        end else if (r_kind == mu8_pkg::KIND_NONE) begin
            n_kind = lead2 ? mu8_pkg::KIND_TWO : mu8_pkg::KIND_THREE;
        end else if (enter_six) begin
            n_kind = mu8_pkg::KIND_SIX;
        end
    end

    // outputs
    always_comb begin
        grp      = '0;
        grp.last = i_in.in_last;
        if ((r_kind == mu8_pkg::KIND_NONE) && !(lead2 || lead3)) begin
            grp.bytes[0] = i_in.in_byte;
            grp.num      = 3'd1;
        end else if (flush) begin
            grp.bytes = wb[4:0];
            grp.num   = kept;
        end else if (done) begin
            case (r_kind)
                mu8_pkg::KIND_TWO: begin
                    if (wb[0] == mu8_pkg::BYTE_C0 && wb[1] == mu8_pkg::BYTE_80) begin
                        grp.bytes[0] = mu8_pkg::BYTE_NUL;
                        grp.num      = 3'd1;
                    end else begin
                        grp.bytes[0] = wb[0];
                        grp.bytes[1] = wb[1];
                        grp.num      = 3'd2;
                    end
                end
                mu8_pkg::KIND_THREE: begin
                    grp.bytes[0] = wb[0];
                    grp.bytes[1] = wb[1];
                    grp.bytes[2] = wb[2];
                    grp.num      = 3'd3;
                end
                mu8_pkg::KIND_SIX: begin
                    grp.bytes[0] = mu8_pkg::LEAD4_PFX | {5'd0, cp[20:18]};
                    grp.bytes[1] = mu8_pkg::CONT_PFX  | {2'd0, cp[17:12]};
                    grp.bytes[2] = mu8_pkg::CONT_PFX  | {2'd0, cp[11:6]};
                    grp.bytes[3] = mu8_pkg::CONT_PFX  | {2'd0, cp[5:0]};
                    grp.num      = 3'd4;
                end
                default: begin
                    grp.num = 3'd0;
                end
            endcase
        end
    end

    assign i_in.ready    = i_push_ready;
    assign o_push_valid  = accept && (grp.num != 3'd0);
    assign o_push_group  = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= mu8_pkg::KIND_NONE;
            r_cnt  <= '0;
        end else if (accept) begin
            r_kind <= n_kind;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= wb[4:0];
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5)
        else $error("held byte count out of range");

    a_kind_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == mu8_pkg::KIND_NONE) == (r_cnt == 3'd0))
        else $error("sequence kind and held count disagree");

    a_two_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == mu8_pkg::KIND_TWO) |-> (r_cnt == 3'd1))
        else $error("two-byte sequence holds wrong count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |=> (r_cnt == 3'd0))
        else $error("sequence left open after stream end");

endmodule

`default_nettype wire

### src/mu8_queue.sv
// mu8_queue: short FIFO of output groups between front and back.
// Depends on mu8_pkg.
`default_nettype none

module mu8_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    output logic             o_push_ready,
    input  mu8_pkg::t_group  i_push_group,
    output logic             o_pop_valid,
    input  wire              i_pop_ready,
    output mu8_pkg::t_group  o_pop_group
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mu8_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            push, pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_group  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_group;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue overfilled");

    a_no_empty_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (i_push_group.num != '0))
        else $error("empty group queued");

    a_ptrs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

### src/mu8_back.sv
// mu8_back: sends the bytes of each queued group one per transaction.
// Depends on mu8_pkg and mu8_out_if.
`default_nettype none

module mu8_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_pop_valid,
    output logic             o_pop_ready,
    input  mu8_pkg::t_group  i_pop_group,
    mu8_out_if.source        o_out
);

    logic [mu8_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                      fin, send;

    assign fin   = r_idx == (i_pop_group.num - 1'b1);
    assign send  = o_out.valid && o_out.ready;
    assign n_idx = fin ? '0 : r_idx + 1'b1;

    assign o_out.valid      = i_pop_valid;
    assign o_out.out_byte   = i_pop_group.bytes[r_idx];
    assign o_out.run_last   = fin;
    assign o_out.stream_end = fin && i_pop_group.last;
    assign o_pop_ready      = o_out.ready && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (send) begin
            r_idx <= n_idx;
        end
    end

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop_valid |-> (r_idx < i_pop_group.num))
        else $error("byte index beyond group");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pop_valid |-> (r_idx == '0))
        else $error("byte index left mid-group with queue empty");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (send && fin) |=> (r_idx == '0))
        else $error("byte index not returned after group");

endmodule

`default_nettype wire

### src/modified_utf8_to_utf8_converter_core.sv
// modified_utf8_to_utf8_converter_core: top level, front + group queue + back.
// Depends on mu8_pkg, mu8_in_if, mu8_out_if, mu8_front, mu8_queue, mu8_back.
//
//  channel | dir | payload                          | handshake
//  i_in    | in  | in_byte[7:0], in_last            | valid/ready
//  o_out   | out | out_byte[7:0], run_last, stream_end | valid/ready
//
// One input byte per cycle is taken while the group queue has room; any output
// group that it completes is written into the queue as it is taken. The back end
// sends one byte per cycle while o_out is ready; a group holds 1 to 5 bytes.
// Synchronous active-low reset clears the sequence state, queue and byte index.
// Input and output stall independently; the queue (QUEUE_DEPTH groups) sits between.
`default_nettype none

module modified_utf8_to_utf8_converter_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    mu8_in_if.sink  i_in,
    mu8_out_if.source o_out
);

    logic            push_valid, push_ready, pop_valid, pop_ready;
    mu8_pkg::t_group push_group, pop_group;

    mu8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_group (push_group)
    );

    mu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_group (push_group),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_group  (pop_group)
    );

    mu8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_group (pop_group),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
